### src/period_jitter_histogram_macros.svh
// assertion helpers used by period_jitter_histogram.sv
`ifndef PERIOD_JITTER_HISTOGRAM_MACROS_SVH
`define PERIOD_JITTER_HISTOGRAM_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define PJH_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define PJH_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pjh_pkg.sv
package pjh_pkg;

	localparam int STAMP_W = 36;
	localparam int NOM_W = 35;
	localparam int TOL_W = 30;
	localparam int BINW_W = 27;
	localparam int CFG_DATA_W = 35;
	localparam int CNT_W = 32;
	localparam int SUM_W = 63;
	localparam int BIN_W = 5;
	localparam int BIN_COUNT = 27;
	localparam int THR_COUNT = 15;
	localparam int THR_W = 31;
	localparam int STEP_W = 4;

	localparam logic [STAMP_W-1:0] WRAP_NS = 36'd60000000000;
	localparam logic [STAMP_W-1:0] MIN_NONE = '1;

	localparam logic [NOM_W-1:0] NOMINAL_RESET = 35'd1000000000;
	localparam logic [TOL_W-1:0] TOLERANCE_RESET = 30'd10000000;
	localparam logic [BINW_W-1:0] BIN_WIDTH_RESET = 27'd500000;

	localparam logic [BIN_W-1:0] BIN_EXACT = 5'd0;
	localparam logic [BIN_W-1:0] BIN_LATE_NEAR_BASE = 5'd1;
	localparam logic [BIN_W-1:0] BIN_LATE_FAR_BASE = 5'd11;
	localparam logic [BIN_W-1:0] BIN_EARLY_BASE = 5'd11;
	localparam logic [BIN_W-1:0] BIN_EARLY_OPEN = 5'd20;
	localparam logic [STEP_W-1:0] LATE_NEAR_STEPS = 4'd10;
	localparam logic [STEP_W-1:0] EARLY_STEPS = 4'd9;

	typedef enum logic [1:0] {
		CFG_NOMINAL = 2'd0,
		CFG_TOLERANCE = 2'd1,
		CFG_BIN_WIDTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp_ns;
	} stamp_beat_t;

	typedef struct packed {
		logic is_first;
		logic [STAMP_W-1:0] period_ns;
		logic is_outlier;
		logic [BIN_W-1:0] bin_index;
		logic [CNT_W-1:0] bin_total;
		logic [CNT_W-1:0] outlier_total;
		logic [CNT_W-1:0] accepted_total;
		logic [SUM_W-1:0] period_sum_ns;
		logic [STAMP_W-1:0] early_max_ns;
		logic [STAMP_W-1:0] early_min_ns;
		logic [STAMP_W-1:0] late_max_ns;
		logic [STAMP_W-1:0] late_min_ns;
	} result_beat_t;

endpackage

### src/pjh_stream_if.sv
interface pjh_stream_if #(
	parameter type data_t = logic
);
	logic valid;
	logic ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/period_jitter_histogram.sv
// Period jitter histogram. Takes one timestamp beat per cycle unless the result side stalls, and
// returns one result beat per timestamp, in order, once it has passed all four registers. The
// path is a four-register pipeline (reduced stamp, period, deviation and bin choice, counter
// update) that moves as a whole: a stall on the result side holds every stage, and the stamp
// side is ready whenever the result register is empty or being taken. The 27 bin counters and
// all totals sit in flip-flops cleared by reset, so no clearing pass follows reset. Bin limits
// are multiples of the bin width formed from the configuration registers, which are to be
// written only while no beat is in flight.
`include "period_jitter_histogram_macros.svh"

module period_jitter_histogram (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [pjh_pkg::CFG_DATA_W-1:0] cfg_data,
	pjh_stream_if.sink stamps,
	pjh_stream_if.source results
);

	localparam int SW = pjh_pkg::STAMP_W;

	logic [pjh_pkg::NOM_W-1:0] nominal_q;
	logic [pjh_pkg::TOL_W-1:0] tolerance_q;
	logic [pjh_pkg::BINW_W-1:0] bin_width_q;

	logic adv;
	logic v_s1, v_s2, v_s3, res_valid_q;

	logic [SW-1:0] stamp_in;
	logic [SW-1:0] stamp_red;
	logic [SW-1:0] stamp_s1;

	logic [SW-1:0] last_q;
	logic have_q;
	logic [SW-1:0] period_calc;
	logic first_s2;
	logic [SW-1:0] period_s2;

	logic [SW-1:0] nom_ext;
	logic [SW-1:0] lo_lim;
	logic [SW-1:0] hi_lim;
	logic [pjh_pkg::BINW_W-1:0] w_eff;
	logic [pjh_pkg::THR_W-1:0] thr [pjh_pkg::THR_COUNT];
	logic [pjh_pkg::THR_COUNT-1:0] ge;
	logic [pjh_pkg::STEP_W-1:0] steps;
	logic early_c;
	logic outl_c;
	logic [SW-1:0] dev_c;
	logic [pjh_pkg::BIN_W-1:0] bin_c;

	logic first_s3, early_s3, outl_s3;
	logic [SW-1:0] period_s3;
	logic [SW-1:0] dev_s3;
	logic [pjh_pkg::BIN_W-1:0] bin_s3;

	logic [pjh_pkg::CNT_W-1:0] bins_q [pjh_pkg::BIN_COUNT];
	logic [pjh_pkg::CNT_W-1:0] outl_cnt_q, acc_cnt_q;
	logic [pjh_pkg::SUM_W-1:0] sum_q;
	logic [SW-1:0] early_hi_q, early_lo_q, late_hi_q, late_lo_q;

	logic [pjh_pkg::CNT_W-1:0] bin_old, bin_new;
	logic [pjh_pkg::SUM_W:0] sum_ext;
	logic [pjh_pkg::SUM_W-1:0] sum_new;

	logic res_first_q, res_outl_q;
	logic [SW-1:0] res_period_q;
	logic [pjh_pkg::BIN_W-1:0] res_bin_q;
	logic [pjh_pkg::CNT_W-1:0] res_bin_total_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= pjh_pkg::NOMINAL_RESET;
			tolerance_q <= pjh_pkg::TOLERANCE_RESET;
			bin_width_q <= pjh_pkg::BIN_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pjh_pkg::CFG_NOMINAL: nominal_q <= cfg_data;
				pjh_pkg::CFG_TOLERANCE: tolerance_q <= cfg_data[pjh_pkg::TOL_W-1:0];
				pjh_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_data[pjh_pkg::BINW_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe moves when the result register is free
	assign adv = !res_valid_q || results.ready;
	assign stamps.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= stamps.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			res_valid_q <= v_s3;
		end
	end

	// stage 1: stamp folded into the wrap
	assign stamp_in = stamps.data.stamp_ns;
	assign stamp_red = (stamp_in >= pjh_pkg::WRAP_NS) ? stamp_in - pjh_pkg::WRAP_NS : stamp_in;

	always_ff @(posedge clk) begin
		if (adv) begin
			stamp_s1 <= stamp_red;
		end
	end

	// stage 2: period against the baseline
	assign period_calc = (stamp_s1 >= last_q) ? stamp_s1 - last_q
		: stamp_s1 - last_q + pjh_pkg::WRAP_NS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			have_q <= 1'b0;
		end else if (adv && v_s1) begin
			last_q <= stamp_s1;
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s2 <= !have_q;
			period_s2 <= have_q ? period_calc : '0;
		end
	end

	// stage 3: deviation, tolerance and bin choice
	assign nom_ext = SW'(nominal_q);
	assign lo_lim = (nominal_q > pjh_pkg::NOM_W'(tolerance_q))
		? nom_ext - SW'(tolerance_q) : '0;
	assign hi_lim = nom_ext + SW'(tolerance_q);
	assign w_eff = (bin_width_q == '0) ? pjh_pkg::BINW_W'(1) : bin_width_q;

	always_comb begin
		for (int j = 0; j < pjh_pkg::THR_COUNT; j++) begin
			thr[j] = pjh_pkg::THR_W'(w_eff) * pjh_pkg::THR_W'(j + 1);
			ge[j] = dev_c >= SW'(thr[j]);
		end
	end

	assign early_c = period_s2 < nom_ext;
	assign dev_c = early_c ? nom_ext - period_s2 : period_s2 - nom_ext;
	assign outl_c = !first_s2 && ((period_s2 < lo_lim) || (period_s2 > hi_lim));
	assign steps = pjh_pkg::STEP_W'($countones(ge));

	always_comb begin
		if (first_s2 || outl_c || (period_s2 == nom_ext)) begin
			bin_c = pjh_pkg::BIN_EXACT;
		end else if (early_c) begin
			if (steps >= pjh_pkg::EARLY_STEPS) begin
				bin_c = pjh_pkg::BIN_EARLY_OPEN;
			end else begin
				bin_c = pjh_pkg::BIN_EARLY_BASE + pjh_pkg::BIN_W'(steps);
			end
		end else if (steps < pjh_pkg::LATE_NEAR_STEPS) begin
			bin_c = pjh_pkg::BIN_LATE_NEAR_BASE + pjh_pkg::BIN_W'(steps);
		end else begin
			// far late bins, the top step count lands in the open bin
			bin_c = pjh_pkg::BIN_LATE_FAR_BASE + pjh_pkg::BIN_W'(steps);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s3 <= first_s2;
			period_s3 <= period_s2;
			early_s3 <= early_c;
			outl_s3 <= outl_c;
			dev_s3 <= dev_c;
			bin_s3 <= bin_c;
		end
	end

	// stage 4: counters, sum and extremes
	assign bin_old = bins_q[bin_s3];
	assign bin_new = (bin_old == '1) ? bin_old : bin_old + 1'b1;
	assign sum_ext = {1'b0, sum_q} + (pjh_pkg::SUM_W + 1)'(period_s3);
	assign sum_new = sum_ext[pjh_pkg::SUM_W] ? '1 : sum_ext[pjh_pkg::SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pjh_pkg::BIN_COUNT; i++) begin
				bins_q[i] <= '0;
			end
			outl_cnt_q <= '0;
			acc_cnt_q <= '0;
			sum_q <= '0;
			early_hi_q <= '0;
			early_lo_q <= pjh_pkg::MIN_NONE;
			late_hi_q <= '0;
			late_lo_q <= pjh_pkg::MIN_NONE;
		end else if (adv && v_s3 && !first_s3) begin
			if (early_s3) begin
				if (dev_s3 > early_hi_q) early_hi_q <= dev_s3;
				if (dev_s3 < early_lo_q) early_lo_q <= dev_s3;
			end else begin
				if (period_s3 > late_hi_q) late_hi_q <= period_s3;
				if (period_s3 < late_lo_q) late_lo_q <= period_s3;
			end
			if (outl_s3) begin
				if (outl_cnt_q != '1) outl_cnt_q <= outl_cnt_q + 1'b1;
			end else begin
				if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + 1'b1;
				sum_q <= sum_new;
				bins_q[bin_s3] <= bin_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_first_q <= first_s3;
			res_period_q <= period_s3;
			res_outl_q <= outl_s3;
			res_bin_q <= bin_s3;
			res_bin_total_q <= (first_s3 || outl_s3) ? '0 : bin_new;
		end
	end

	// totals and extremes only change as a beat enters the result register
	assign results.valid = res_valid_q;
	assign results.data.is_first = res_first_q;
	assign results.data.period_ns = res_period_q;
	assign results.data.is_outlier = res_outl_q;
	assign results.data.bin_index = res_bin_q;
	assign results.data.bin_total = res_bin_total_q;
	assign results.data.outlier_total = outl_cnt_q;
	assign results.data.accepted_total = acc_cnt_q;
	assign results.data.period_sum_ns = sum_q;
	assign results.data.early_max_ns = early_hi_q;
	assign results.data.early_min_ns = early_lo_q;
	assign results.data.late_max_ns = late_hi_q;
	assign results.data.late_min_ns = late_lo_q;

	`PJH_ASSERT_IMP(a_outlier_no_bin, res_valid_q && res_outl_q, (res_bin_q == pjh_pkg::BIN_EXACT) && (res_bin_total_q == '0), "outlier beat carries a bin")
	`PJH_ASSERT_IMP(a_first_clean, res_valid_q && res_first_q, (res_period_q == '0) && !res_outl_q, "baseline beat carries a period")
	`PJH_ASSERT_IMP(a_early_order, early_lo_q != pjh_pkg::MIN_NONE, early_lo_q <= early_hi_q, "early extremes out of order")
	`PJH_ASSERT_IMP(a_late_order, late_lo_q != pjh_pkg::MIN_NONE, late_lo_q <= late_hi_q, "late extremes out of order")
	`PJH_ASSERT_NEXT(a_first_once, results.valid && results.ready, !(res_valid_q && res_first_q), "second baseline beat")

endmodule

### tb/jitter_checker.sv
`timescale 1ns / 100ps

module jitter_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [pjh_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic stamp_valid,
	input logic stamp_ready,
	input pjh_pkg::stamp_beat_t stamp_data,
	input logic result_valid,
	input logic result_ready,
	input pjh_pkg::result_beat_t result_data,
	output int mismatches,
	output int compared,
	output int pending
);
	import pjh_pkg::*;

	localparam int EXACT_BIN = 0;
	localparam int LATE_NEAR_FIRST = 1;
	localparam int LATE_NEAR_SPAN = 10;
	localparam int LATE_FAR_FIRST = 21;
	localparam int LATE_OPEN_STEP = 15;
	localparam int LATE_OPEN_BIN = 26;
	localparam int EARLY_FIRST = 11;
	localparam int EARLY_SPAN = 9;
	localparam int EARLY_OPEN_BIN = 20;
	localparam logic [63:0] WRAP64 = 64'(WRAP_NS);
	localparam logic [SUM_W-1:0] SUM_FULL = '1;

	logic [NOM_W-1:0] nominal;
	logic [TOL_W-1:0] tolerance;
	logic [BINW_W-1:0] bin_width;

	logic [STAMP_W-1:0] base_stamp;
	logic base_valid;
	logic [CNT_W-1:0] bin_tally [BIN_COUNT];
	logic [CNT_W-1:0] outlier_tally;
	logic [CNT_W-1:0] accepted_tally;
	logic [SUM_W-1:0] period_total;
	logic [STAMP_W-1:0] early_worst;
	logic [STAMP_W-1:0] early_best;
	logic [STAMP_W-1:0] late_worst;
	logic [STAMP_W-1:0] late_best;

	result_beat_t awaited_stats [$];

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [BIN_W-1:0] deviation_bin(logic [63:0] per);
		logic [63:0] w;
		logic [63:0] k;
		w = (bin_width == '0) ? 64'd1 : 64'(bin_width);
		if (per == 64'(nominal))
			return BIN_W'(EXACT_BIN);
		if (per > 64'(nominal)) begin
			k = (per - 64'(nominal)) / w;
			if (k < LATE_NEAR_SPAN)
				return BIN_W'(LATE_NEAR_FIRST + k);
			if (k < LATE_OPEN_STEP)
				return BIN_W'(LATE_FAR_FIRST + k - LATE_NEAR_SPAN);
			return BIN_W'(LATE_OPEN_BIN);
		end
		k = (64'(nominal) - per) / w;
		if (k < EARLY_SPAN)
			return BIN_W'(EARLY_FIRST + k);
		return BIN_W'(EARLY_OPEN_BIN);
	endfunction

	task automatic predict_period(input logic [STAMP_W-1:0] raw, output result_beat_t r);
		logic [63:0] stamp;
		logic [63:0] per;
		logic [63:0] lo_lim;
		logic [63:0] hi_lim;
		logic [63:0] short;
		logic [BIN_W-1:0] bin;
		r = '0;
		per = '0;
		stamp = 64'(raw) % WRAP64;
		if (!base_valid) begin
			r.is_first = 1'b1;
		end else begin
			per = (stamp + WRAP64 - 64'(base_stamp)) % WRAP64;
			if (per < 64'(nominal)) begin
				short = 64'(nominal) - per;
				if (short > 64'(early_worst))
					early_worst = short[STAMP_W-1:0];
				if (short < 64'(early_best))
					early_best = short[STAMP_W-1:0];
			end else begin
				if (per > 64'(late_worst))
					late_worst = per[STAMP_W-1:0];
				if (per < 64'(late_best))
					late_best = per[STAMP_W-1:0];
			end
			lo_lim = (nominal > tolerance) ? 64'(nominal) - 64'(tolerance) : 64'd0;
			hi_lim = 64'(nominal) + 64'(tolerance);
			if (per < lo_lim || per > hi_lim) begin
				r.is_outlier = 1'b1;
				outlier_tally = bump(outlier_tally);
			end else begin
				accepted_tally = bump(accepted_tally);
				if (64'(period_total) + per > 64'(SUM_FULL))
					period_total = SUM_FULL;
				else
					period_total = period_total + per[SUM_W-1:0];
				bin = deviation_bin(per);
				bin_tally[bin] = bump(bin_tally[bin]);
				r.bin_index = bin;
				r.bin_total = bin_tally[bin];
			end
		end
		base_stamp = stamp[STAMP_W-1:0];
		base_valid = 1'b1;
		r.period_ns = per[STAMP_W-1:0];
		r.outlier_total = outlier_tally;
		r.accepted_total = accepted_tally;
		r.period_sum_ns = period_total;
		r.early_max_ns = early_worst;
		r.early_min_ns = early_best;
		r.late_max_ns = late_worst;
		r.late_min_ns = late_best;
	endtask

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_beat_t want;
		result_beat_t fresh;
		if (!arst_n) begin
			nominal = NOMINAL_RESET;
			tolerance = TOLERANCE_RESET;
			bin_width = BIN_WIDTH_RESET;
			base_stamp = '0;
			base_valid = 1'b0;
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			outlier_tally = '0;
			accepted_tally = '0;
			period_total = '0;
			early_worst = '0;
			early_best = MIN_NONE;
			late_worst = '0;
			late_best = MIN_NONE;
			awaited_stats.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_NOMINAL: nominal = cfg_data[NOM_W-1:0];
					CFG_TOLERANCE: tolerance = cfg_data[TOL_W-1:0];
					CFG_BIN_WIDTH: bin_width = cfg_data[BINW_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited_stats.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					want = awaited_stats.pop_front();
					check_field("is_first", want.is_first, result_data.is_first);
					check_field("period_ns", want.period_ns, result_data.period_ns);
					check_field("is_outlier", want.is_outlier, result_data.is_outlier);
					check_field("bin_index", want.bin_index, result_data.bin_index);
					check_field("bin_total", want.bin_total, result_data.bin_total);
					check_field("outlier_total", want.outlier_total,
						result_data.outlier_total);
					check_field("accepted_total", want.accepted_total,
						result_data.accepted_total);
					check_field("period_sum_ns", want.period_sum_ns,
						result_data.period_sum_ns);
					check_field("early_max_ns", want.early_max_ns, result_data.early_max_ns);
					check_field("early_min_ns", want.early_min_ns, result_data.early_min_ns);
					check_field("late_max_ns", want.late_max_ns, result_data.late_max_ns);
					check_field("late_min_ns", want.late_min_ns, result_data.late_min_ns);
					compared++;
				end
			end
			if (stamp_valid && stamp_ready) begin
				predict_period(stamp_data.stamp_ns, fresh);
				awaited_stats.push_back(fresh);
			end
			pending <= awaited_stats.size();
		end
	end

	initial begin
		mismatches = 0;
		compared = 0;
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import pjh_pkg::*;

	localparam longint WRAP_L = longint'(WRAP_NS);
	localparam longint BEYOND_SPAN = 64'h10_0000_0000 - WRAP_L;
	localparam int HOLD_CYCLES = 400;
	localparam int RUN_LIMIT = 500000;
	localparam int PHASE_ITEMS = 150;

	typedef struct {
		logic [NOM_W-1:0] nom;
		logic [TOL_W-1:0] tol;
		logic [BINW_W-1:0] width;
	} setting_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pjh_stream_if #(.data_t(stamp_beat_t)) stamp_ch ();
	pjh_stream_if #(.data_t(result_beat_t)) result_ch ();

	int mismatches;
	int compared;
	int pending;
	int stamps_sent;
	int settings_used;
	int cycle_count;
	bit quiet;
	bit long_hold;

	logic [NOM_W-1:0] set_nominal;
	logic [TOL_W-1:0] set_tolerance;
	logic [BINW_W-1:0] set_width;
	logic [63:0] prev_stamp;

	setting_t plan [7];

	period_jitter_histogram uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.stamps(stamp_ch),
		.results(result_ch)
	);

	jitter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.stamp_valid(stamp_ch.valid),
		.stamp_ready(stamp_ch.ready),
		.stamp_data(stamp_ch.data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data(result_ch.data),
		.mismatches(mismatches),
		.compared(compared),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic drain_results();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_setting(setting_t s);
		stamp_ch.valid <= 1'b0;
		drain_results();
		write_reg(CFG_NOMINAL, CFG_DATA_W'(s.nom));
		write_reg(CFG_TOLERANCE, CFG_DATA_W'(s.tol));
		write_reg(CFG_BIN_WIDTH, CFG_DATA_W'(s.width));
		cfg_wr_en <= 1'b0;
		set_nominal = s.nom;
		set_tolerance = s.tol;
		set_width = s.width;
		settings_used++;
	endtask

	task automatic send_stamp(logic [STAMP_W-1:0] s);
		stamp_ch.valid <= 1'b1;
		stamp_ch.data.stamp_ns <= s;
		do @(posedge clk); while (!stamp_ch.ready);
		prev_stamp = 64'(s) % 64'(WRAP_L);
		stamps_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			stamp_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// stamp one nominal period plus dev after the previous one
	task automatic send_offset(longint dev);
		longint p;
		longint s;
		p = (longint'(set_nominal) + dev) % WRAP_L;
		if (p < 0)
			p += WRAP_L;
		s = (longint'(prev_stamp) + p) % WRAP_L;
		if (s < BEYOND_SPAN && $urandom_range(0, 15) == 0)
			s += WRAP_L;
		send_stamp(s[STAMP_W-1:0]);
	endtask

	function automatic longint random_dev();
		longint w;
		longint k;
		longint d;
		w = (set_width == '0) ? 64'd1 : longint'(set_width);
		case ($urandom_range(0, 9))
			0: d = 0;
			1: d = longint'(set_tolerance) + longint'($urandom_range(0, 2)) - 1;
			default: begin
				k = longint'($urandom_range(0, 16));
				d = k * w + longint'($urandom_range(0, 32'(w - 1)));
			end
		endcase
		if ($urandom_range(0, 1))
			d = -d;
		return d;
	endfunction

	task automatic run_random(int count);
		logic [3:0] top_bits;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 19))
				0, 1: begin
					top_bits = 4'($urandom_range(0, 15));
					send_stamp({top_bits, 32'($urandom)});
				end
				2: send_stamp(prev_stamp[STAMP_W-1:0]);
				default: send_offset(random_dev());
			endcase
		end
	endtask

	// result side: random back-pressure, one long hold, none at the end
	initial begin
		int gap;
		gap = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (quiet) begin
				result_ch.ready <= 1'b1;
			end else if (gap > 0) begin
				gap--;
			end else if ($urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				gap = $urandom_range(0, 14);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		longint w;
		cycle_count = 0;
		stamps_sent = 0;
		settings_used = 1;
		quiet = 1'b0;
		long_hold = 1'b0;
		prev_stamp = '0;
		set_nominal = NOMINAL_RESET;
		set_tolerance = TOLERANCE_RESET;
		set_width = BIN_WIDTH_RESET;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_NOMINAL;
		cfg_data <= '0;
		stamp_ch.valid <= 1'b0;
		stamp_ch.data <= '0;

		plan[0] = '{NOM_W'(1), TOL_W'(5), BINW_W'(1)};
		plan[1] = '{NOM_W'(30000000000), TOL_W'(1000000000), BINW_W'(100000000)};
		plan[2] = '{NOM_W'(1000000), TOL_W'(1000000), BINW_W'(50000)};
		plan[3] = '{NOM_W'(2500), TOL_W'(40), BINW_W'(0)};
		plan[4].nom = NOM_W'({$urandom_range(0, 6), $urandom}) % NOM_W'(30000000000) + 1'b1;
		plan[4].tol = TOL_W'($urandom_range(0, 1000000000));
		plan[4].width = BINW_W'($urandom_range(1, 100000000));
		plan[5] = '{'1, '1, '1};
		plan[6] = '{NOMINAL_RESET, TOLERANCE_RESET, BIN_WIDTH_RESET};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge cases at the reset settings
		w = longint'(set_width);
		send_stamp('0);
		send_stamp('0);
		send_offset(0);
		send_offset(longint'(set_tolerance));
		send_offset(longint'(set_tolerance) + 1);
		send_offset(-longint'(set_tolerance));
		send_offset(-longint'(set_tolerance) - 1);
		send_offset(w - 1);
		send_offset(w);
		send_offset(10 * w - 1);
		send_offset(10 * w);
		send_offset(15 * w - 1);
		send_offset(15 * w);
		send_offset(-1);
		send_offset(-(9 * w - 1));
		send_offset(-(9 * w));
		send_stamp('1);
		send_stamp(STAMP_W'(WRAP_L - 1));
		send_offset(1);
		send_stamp(STAMP_W'(WRAP_L));
		send_offset(0);
		run_random(PHASE_ITEMS);

		foreach (plan[i]) begin
			apply_setting(plan[i]);
			if (i == 6)
				quiet = 1'b1;
			if (i == 1 || i == 2) begin
				run_random(PHASE_ITEMS / 3);
				if (i == 1) begin
					long_hold = 1'b1;
				end else begin
					stamp_ch.valid <= 1'b0;
					drain_results();
				end
				run_random(PHASE_ITEMS - PHASE_ITEMS / 3);
			end else begin
				run_random(PHASE_ITEMS);
			end
		end

		stamp_ch.valid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		$display("sent %0d timestamp beats across %0d register settings", stamps_sent,
			settings_used);
		$display("compared %0d result beats, %0d field mismatches", compared, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### period_jitter_histogram.f
+incdir+src
src/pjh_pkg.sv
src/pjh_stream_if.sv
src/period_jitter_histogram.sv
tb/jitter_checker.sv
tb/tb.sv
